// ----- rtl/iccl_pkg.sv -----
// ----------------------------------------------------------------------------
// iccl_pkg
// Shared types and constants for the classful subnet classifier.
// ----------------------------------------------------------------------------
package iccl_pkg;

    localparam int NUM_ENTRIES = 8;
    localparam int IDX_W       = 3;
    localparam logic [31:0] ALL_ONES = 32'hffffffff;

    localparam logic [2:0] KIND_SET_ADDR  = 3'd0;
    localparam logic [2:0] KIND_SET_MASK  = 3'd1;
    localparam logic [2:0] KIND_SET_BCAST = 3'd2;
    localparam logic [2:0] KIND_QUERY     = 3'd3;
    localparam logic [2:0] KIND_MAKE      = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_NO_BCST = 2'd2;

    localparam int QDEPTH = 2;

    // decoded item passed from front to back
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  entry;
        logic [31:0] address;
        logic [31:0] host;
        logic        bcap;
    } item_t;

    function automatic logic [31:0] class_mask(input logic [31:0] a);
        logic [31:0] m;
        if (!a[31])            m = 32'hff000000;
        else if (a[31:30] == 2'b10) m = 32'hffff0000;
        else                   m = 32'hffffff00;
        return m;
    endfunction

endpackage

// ----- rtl/ipv4_classful_subnet_classifier.sv -----
// ----------------------------------------------------------------------------
// ipv4_classful_subnet_classifier
// Classful IPv4 interface table with query and make-address operations.
// Path: each input transaction passes through the queue, then the executor.
// Throughput: one item per cycle unless the output stalls; set-address with
// broadcast holds the queue while broadcast is made from the updated table.
// Reset: asynchronous rst_n clears the table, queue and output valid; config = 1.
// ----------------------------------------------------------------------------
module ipv4_classful_subnet_classifier
    import iccl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [2:0]   s_tuser,  // kind
    input  logic [71:0]  s_tdata,  // entry, address, host, broadcast_capable
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, net_number, host_part, is_local, is_broadcast, made_address
    output logic [103:0] m_tdata
);
    logic  q_valid, q_pop;
    item_t q_item;

    iccl_front u_front (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tuser(s_tuser), .s_tdata(s_tdata), .q_valid(q_valid), .q_pop(q_pop),
        .q_item(q_item)
    );

    iccl_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );
endmodule

// ----- rtl/iccl_front.sv -----
// ----------------------------------------------------------------------------
// iccl_front
// Accepts items, drops unused kinds, and queues the rest for the back end.
// ----------------------------------------------------------------------------
module iccl_front
    import iccl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,
    input  logic [71:0] s_tdata,
    output logic        q_valid,
    input  logic        q_pop,
    output item_t       q_item
);
    item_t       mem_reg [QDEPTH];
    logic        wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    item_t       in_item;
    logic        push;

    always_comb
    begin
        in_item.kind    = s_tuser;
        in_item.entry   = s_tdata[2:0];
        in_item.address = s_tdata[34:3];
        in_item.host    = s_tdata[66:35];
        in_item.bcap    = s_tdata[67];
    end

    assign s_tready = (cnt_reg != 2'(QDEPTH));
    assign push     = s_tvalid && s_tready && (in_item.kind <= KIND_MAKE);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_item;
    end
endmodule

// ----- rtl/iccl_back.sv -----
// ----------------------------------------------------------------------------
// iccl_back
// Interface table and executor: writes, queries and address make-up.
// ----------------------------------------------------------------------------
module iccl_back
    import iccl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,
    input  logic         q_valid,
    output logic         q_pop,
    input  item_t        q_item,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata
);
    logic [NUM_ENTRIES-1:0] pres_reg, bok_reg;
    logic [31:0] net_reg [NUM_ENTRIES];
    logic [31:0] cm_reg  [NUM_ENTRIES];
    logic [31:0] sm_reg  [NUM_ENTRIES];
    logic [31:0] sn_reg  [NUM_ENTRIES];
    logic [31:0] ba_reg  [NUM_ENTRIES];
    logic        sal_reg;
    // second phase of set-address: broadcast computed from the updated table
    logic        bc_pend_reg;
    logic [IDX_W-1:0] bc_idx_reg;
    logic        ov_reg;
    logic [103:0] od_reg;

    logic        go;
    logic [31:0] a, mk_net, mk_host, mk_mask, cmq, nm, res_net, res_host, bnm;
    logic        class_e, loc, bc, found, q_found;
    logic [1:0]  status;
    logic [31:0] made, new_sm;

    assign cfg_ready = 1'b1;
    assign go    = q_valid && !bc_pend_reg && (!ov_reg || m_tready);
    assign q_pop = go;
    assign a     = q_item.address;

    // make-address lookup, shared by kind 4 and the broadcast phase
    always_comb
    begin
        mk_net  = bc_pend_reg ? sn_reg[bc_idx_reg] : a;
        mk_host = bc_pend_reg ? ALL_ONES : q_item.host;
        mk_mask = ~class_mask(mk_net);
        found   = 1'b0;
        for (int k = 0; k < NUM_ENTRIES; k++)
            if (!found && pres_reg[k] && ((cm_reg[k] & mk_net) == net_reg[k]))
            begin
                found   = 1'b1;
                mk_mask = ~sm_reg[k];
            end
        made = mk_net | (mk_host & mk_mask);
    end

    always_comb
    begin
        class_e = 1'b0;
        nm      = 32'h0;
        priority if (!a[31])               nm = 32'hff000000;
        else if (a[31:30] == 2'b10)        nm = 32'hffff0000;
        else if (a[31:29] == 3'b110)       nm = 32'hffffff00;
        else if (a[31:28] == 4'b1110)      nm = 32'hf0000000;
        else                               class_e = 1'b1;
        cmq      = a & nm;
        res_net  = class_e ? 32'h0 : cmq;
        res_host = class_e ? a : (a & ~nm);
        q_found  = 1'b0;
        if (!class_e)
            for (int k = 0; k < NUM_ENTRIES; k++)
                if (!q_found && pres_reg[k] && cmq == net_reg[k])
                begin
                    q_found  = 1'b1;
                    res_net  = a & sm_reg[k];
                    res_host = (a & ~nm) & ~sm_reg[k];
                end
        loc = 1'b0;
        for (int k = 0; k < NUM_ENTRIES; k++)
            if (pres_reg[k] && (sal_reg ? ((a & cm_reg[k]) == net_reg[k])
                                        : ((a & sm_reg[k]) == sn_reg[k])))
                loc = 1'b1;
        // classes D and E take the class A mask here
        if (a[31:29] == 3'b110)
            bnm = 32'hffffff00;
        else if (a[31:30] == 2'b10)
            bnm = 32'hffff0000;
        else
            bnm = 32'hff000000;
        bc  = ((a | bnm) == ALL_ONES) || (a == ALL_ONES) || (a == 32'h0);
        for (int k = 0; k < NUM_ENTRIES; k++)
            if (pres_reg[k] && bok_reg[k] &&
                (ba_reg[k] == a || sn_reg[k] == a || net_reg[k] == a))
                bc = 1'b1;
        status = ST_OK;
        if (q_item.kind == KIND_SET_BCAST)
        begin
            if (!pres_reg[q_item.entry])     status = ST_ABSENT;
            else if (!bok_reg[q_item.entry]) status = ST_NO_BCST;
        end
        new_sm = sm_reg[q_item.entry] | class_mask(a);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pres_reg    <= '0;
            bok_reg     <= '0;
            sal_reg     <= 1'b1;
            bc_pend_reg <= 1'b0;
            ov_reg      <= 1'b0;
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                net_reg[k] <= '0; cm_reg[k] <= '0; sm_reg[k] <= '0;
                sn_reg[k]  <= '0; ba_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
                sal_reg <= cfg_data;
            if (m_tready && !go)
                ov_reg <= 1'b0;
            if (bc_pend_reg)
            begin
                ba_reg[bc_idx_reg] <= made;
                bc_pend_reg        <= 1'b0;
            end
            if (go)
            begin
                ov_reg <= 1'b1;
                od_reg <= {4'h0, made & {32{q_item.kind == KIND_MAKE}},
                           bc && q_item.kind == KIND_QUERY,
                           loc && q_item.kind == KIND_QUERY,
                           res_host & {32{q_item.kind == KIND_QUERY}},
                           res_net & {32{q_item.kind == KIND_QUERY}}, status};
                unique case (q_item.kind)
                    KIND_SET_ADDR:
                    begin
                        pres_reg[q_item.entry] <= 1'b1;
                        bok_reg[q_item.entry]  <= q_item.bcap;
                        cm_reg[q_item.entry]   <= class_mask(a);
                        net_reg[q_item.entry]  <= a & class_mask(a);
                        sm_reg[q_item.entry]   <= new_sm;
                        sn_reg[q_item.entry]   <= a & new_sm;
                        bc_pend_reg            <= q_item.bcap;
                        bc_idx_reg             <= q_item.entry;
                    end
                    KIND_SET_MASK:
                    begin
                        pres_reg[q_item.entry] <= 1'b1;
                        sm_reg[q_item.entry]   <= a;
                    end
                    KIND_SET_BCAST:
                        if (status == ST_OK)
                            ba_reg[q_item.entry] <= a;
                    default: ;
                endcase
            end
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
endmodule
